>>> design/signed_unsigned_int_divider_macros.svh
// ---------------------------------------------------------------------------
// signed_unsigned_int_divider_macros.svh
// Assertion macros for the divider; empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef SIGNED_UNSIGNED_INT_DIVIDER_MACROS_SVH
`define SIGNED_UNSIGNED_INT_DIVIDER_MACROS_SVH

`ifndef SYNTHESIS

// Condition in this cycle implies a consequence in the same cycle
`define SUDIV_ASSERT_NOW(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("divider check failed");

// Condition in this cycle implies a consequence in the next cycle
`define SUDIV_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("divider check failed");

`else

`define SUDIV_ASSERT_NOW(label, clk, rst, cond, cons)
`define SUDIV_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

>>> design/sudiv_pkg.sv
// ---------------------------------------------------------------------------
// sudiv_pkg
// Shared types and constants of the pipelined integer divider.
// ---------------------------------------------------------------------------
package sudiv_pkg;

  // Operand and result width
  localparam int Width = 64;
  // Restoring steps, one per cell
  localparam int DivSteps = 64;
  // Operand width in word mode
  localparam int WordBits = 32;

  // State carried from cell to cell
  typedef struct packed {
    logic             vld;  // stage holds an item
    logic [Width-1:0] hi;   // partial remainder
    logic [Width-1:0] lo;   // dividend bits shifting out, quotient bits in
    logic [Width-1:0] dv;   // divisor magnitude
    logic             rem;  // return the remainder
    logic             inv;  // negate the chosen value
  } stage_t;

endpackage

>>> design/signed_unsigned_int_divider.sv
// An accepted item passes the prep register, the cell row and the output register to valid.
// Throughput: one item per cycle; busy stays low, the row of 64 step cells is fully pipelined.
// Each cell does one restoring step (a 65-bit trial subtract) between registers.
// Reset (rst, synchronous) clears the valid bits of every stage; data is not cleared.
// The receiver cannot stall: each result is present for exactly one cycle.
// ---------------------------------------------------------------------------
// signed_unsigned_int_divider
// Signed/unsigned 64-bit and word-mode integer divider built as a cell row.
// ---------------------------------------------------------------------------
`include "signed_unsigned_int_divider_macros.svh"

module signed_unsigned_int_divider #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [sudiv_pkg::Width-1:0] dividend,
  input  logic [sudiv_pkg::Width-1:0] divisor,
  input  logic                        is_unsigned,
  input  logic                        word_mode,
  input  logic                        want_remainder,
  output logic                        valid,
  output logic [sudiv_pkg::Width-1:0] result
);

  sudiv_pkg::stage_t stg [0:sudiv_pkg::DivSteps];
  logic              take;

  // The pipeline takes an item every cycle
  assign busy = 1'b0;
  assign take = start && !busy;

  // Operand conditioning
  sudiv_prep #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_prep (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .dividend      (dividend),
    .divisor       (divisor),
    .is_unsigned   (is_unsigned),
    .word_mode     (word_mode),
    .want_remainder(want_remainder),
    .stg           (stg[0])
  );

  // Row of division step cells
  for (genvar i = 0; i < sudiv_pkg::DivSteps; i++) begin : g_cell
    sudiv_cell u_cell (
      .clk (clk),
      .rst (rst),
      .prev(stg[i]),
      .stg (stg[i+1])
    );
  end

  // Select and sign-correct
  sudiv_post u_post (
    .clk   (clk),
    .rst   (rst),
    .last  (stg[sudiv_pkg::DivSteps]),
    .valid (valid),
    .result(result)
  );

  // Checks
  `SUDIV_ASSERT_NEXT(a_enter_row, clk, rst, take, stg[0].vld)
  `SUDIV_ASSERT_NEXT(a_row_to_out, clk, rst, stg[sudiv_pkg::DivSteps].vld, valid)
  `SUDIV_ASSERT_NOW(a_out_from_row, clk, rst, valid, $past(stg[sudiv_pkg::DivSteps].vld))

endmodule

>>> design/sudiv_prep.sv
// ---------------------------------------------------------------------------
// sudiv_prep
// Operand conditioning: masking, magnitudes and the sign rule.
// ---------------------------------------------------------------------------
module sudiv_prep #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  logic [sudiv_pkg::Width-1:0]       dividend,
  input  logic [sudiv_pkg::Width-1:0]       divisor,
  input  logic                              is_unsigned,
  input  logic                              word_mode,
  input  logic                              want_remainder,
  output sudiv_pkg::stage_t                 stg
);

  localparam logic [sudiv_pkg::Width-1:0] FullMask =
    {sudiv_pkg::Width{1'b1}} >> (sudiv_pkg::Width - DATA_WIDTH);
  localparam logic [sudiv_pkg::Width-1:0] WordMask =
    {sudiv_pkg::Width{1'b1}} >> (sudiv_pkg::Width - sudiv_pkg::WordBits);

  logic [sudiv_pkg::Width-1:0] mask;
  logic [sudiv_pkg::Width-1:0] a_m, b_m;
  logic [sudiv_pkg::Width-1:0] a_mag, b_mag;
  logic                        sa, sb;
  sudiv_pkg::stage_t           stg_next;

  // Sign bits sit at bit 31 in word mode, at the top of the full width otherwise
  always_comb begin
    mask = word_mode ? WordMask : FullMask;
    a_m  = dividend & mask;
    b_m  = divisor & mask;
    sa   = word_mode ? dividend[sudiv_pkg::WordBits-1] : dividend[DATA_WIDTH-1];
    sb   = word_mode ? divisor[sudiv_pkg::WordBits-1] : divisor[DATA_WIDTH-1];
  end

  // Magnitudes; the most negative value maps onto itself
  always_comb begin
    a_mag = (!is_unsigned && sa) ? ((~a_m + 1'b1) & mask) : a_m;
    b_mag = (!is_unsigned && sb) ? ((~b_m + 1'b1) & mask) : b_m;
  end

  // Entry into the cell row
  always_comb begin
    stg_next.vld = take;
    stg_next.hi  = '0;
    stg_next.lo  = a_mag;
    stg_next.dv  = b_mag;
    stg_next.rem = want_remainder;
    stg_next.inv = !is_unsigned && (want_remainder ? sa : (sa ^ sb));
  end

  // Stage register; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      stg.vld <= 1'b0;
    end else begin
      stg.vld <= stg_next.vld;
    end
    stg.hi  <= stg_next.hi;
    stg.lo  <= stg_next.lo;
    stg.dv  <= stg_next.dv;
    stg.rem <= stg_next.rem;
    stg.inv <= stg_next.inv;
  end

endmodule

>>> design/sudiv_cell.sv
// ---------------------------------------------------------------------------
// sudiv_cell
// One restoring division step with a 65-bit trial subtract, registered.
// ---------------------------------------------------------------------------
module sudiv_cell (
  input  logic              clk,
  input  logic              rst,
  input  sudiv_pkg::stage_t prev,
  output sudiv_pkg::stage_t stg
);

  logic [sudiv_pkg::Width-1:0] t;
  logic [sudiv_pkg::Width:0]   diff;
  logic                        neg;
  sudiv_pkg::stage_t           stg_next;

  // Shift one dividend bit into the partial remainder and try the subtract
  always_comb begin
    t    = {prev.hi[sudiv_pkg::Width-2:0], prev.lo[sudiv_pkg::Width-1]};
    diff = {1'b0, t} - {1'b0, prev.dv};
    neg  = prev.hi[sudiv_pkg::Width-1] ^ diff[sudiv_pkg::Width];
  end

  // Keep or restore, and shift in the quotient bit
  always_comb begin
    stg_next = prev;
    if (neg) begin
      stg_next.hi = t;
      stg_next.lo = {prev.lo[sudiv_pkg::Width-2:0], 1'b0};
    end else begin
      stg_next.hi = diff[sudiv_pkg::Width-1:0];
      stg_next.lo = {prev.lo[sudiv_pkg::Width-2:0], 1'b1};
    end
  end

  // Stage register; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      stg.vld <= 1'b0;
    end else begin
      stg.vld <= stg_next.vld;
    end
    stg.hi  <= stg_next.hi;
    stg.lo  <= stg_next.lo;
    stg.dv  <= stg_next.dv;
    stg.rem <= stg_next.rem;
    stg.inv <= stg_next.inv;
  end

endmodule

>>> design/sudiv_post.sv
// ---------------------------------------------------------------------------
// sudiv_post
// Result selection and sign correction into the output register.
// ---------------------------------------------------------------------------
module sudiv_post (
  input  logic                        clk,
  input  logic                        rst,
  input  sudiv_pkg::stage_t           last,
  output logic                        valid,
  output logic [sudiv_pkg::Width-1:0] result
);

  logic [sudiv_pkg::Width-1:0] pick;
  logic [sudiv_pkg::Width-1:0] result_next;

  // Quotient or remainder, negated modulo 2^64 when the sign rule says so
  always_comb begin
    pick        = last.rem ? last.hi : last.lo;
    result_next = last.inv ? (~pick + 1'b1) : pick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

>>> bench/div_checker.sv
// ---------------------------------------------------------------------------
// div_checker
// Watches the divider's request and result ports, computes each expected
// quotient or remainder at acceptance and compares results in order.
// ---------------------------------------------------------------------------
module div_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [sudiv_pkg::Width-1:0] dividend,
  input  logic [sudiv_pkg::Width-1:0] divisor,
  input  logic                        is_unsigned,
  input  logic                        word_mode,
  input  logic                        want_remainder,
  input  logic                        valid,
  input  logic [sudiv_pkg::Width-1:0] result,
  output int                          failures,
  output int                          pending
);
  localparam int W  = sudiv_pkg::Width;
  localparam int WB = sudiv_pkg::WordBits;

  // Results still owed by the divider, oldest first
  logic [W-1:0] owed_results[$];
  logic [W-1:0] owed;

  // Operand magnitude; word mode keeps the low half, zero-extended
  function automatic logic [W-1:0] operand_mag(logic [W-1:0] v, logic uns, logic word);
    logic [WB-1:0] half;
    logic [W-1:0]  full;
    half = v[WB-1:0];
    full = v;
    if (word) begin
      if (!uns && half[WB-1]) half = -half;
      return {{(W-WB){1'b0}}, half};
    end
    if (!uns && full[W-1]) full = -full;
    return full;
  endfunction

  // Quotient or remainder after the sign rule
  function automatic logic [W-1:0] divide_item(logic [W-1:0] a, logic [W-1:0] b,
                                               logic uns, logic word, logic rem);
    logic [W-1:0] num;
    logic [W-1:0] den;
    logic [W-1:0] quo;
    logic [W-1:0] rmd;
    logic [W-1:0] pick;
    logic         sa;
    logic         sb;
    logic         neg;
    num = operand_mag(a, uns, word);
    den = operand_mag(b, uns, word);
    // divide by zero: all-ones quotient, remainder is the dividend
    if (den == '0) begin
      quo = '1;
      rmd = num;
    end else begin
      quo = num / den;
      rmd = num % den;
    end
    sa   = word ? a[WB-1] : a[W-1];
    sb   = word ? b[WB-1] : b[W-1];
    neg  = !uns && (rem ? sa : (sa != sb));
    pick = rem ? rmd : quo;
    return neg ? -pick : pick;
  endfunction

  // Compare results, then log newly accepted items
  always @(posedge clk) begin
    if (!rst) begin
      if (valid) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, result);
          failures <= failures + 1;
        end else begin
          owed = owed_results.pop_front();
          if (result !== owed) begin
            $display("%0t: result mismatch, expected %h, actual %h", $time, owed, result);
            failures <= failures + 1;
          end
        end
      end
      if (start && !busy)
        owed_results.push_back(divide_item(dividend, divisor, is_unsigned,
                                           word_mode, want_remainder));
      pending <= owed_results.size();
    end
  end

endmodule

>>> bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// Drives directed and random divide requests through the pipelined divider
// under several idle patterns; div_checker predicts and compares results.
// ---------------------------------------------------------------------------
module tb;
  localparam int W  = sudiv_pkg::Width;
  localparam int WB = sudiv_pkg::WordBits;

  logic         clk = 1'b0;
  logic         rst;
  logic         start;
  logic         busy;
  logic [W-1:0] dividend;
  logic [W-1:0] divisor;
  logic         is_unsigned;
  logic         word_mode;
  logic         want_remainder;
  logic         valid;
  logic [W-1:0] result;
  int           failures;
  int           pending;

  always #5 clk = ~clk;

  signed_unsigned_int_divider dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .dividend       (dividend),
    .divisor        (divisor),
    .is_unsigned    (is_unsigned),
    .word_mode      (word_mode),
    .want_remainder (want_remainder),
    .valid          (valid),
    .result         (result)
  );

  div_checker chk (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .dividend       (dividend),
    .divisor        (divisor),
    .is_unsigned    (is_unsigned),
    .word_mode      (word_mode),
    .want_remainder (want_remainder),
    .valid          (valid),
    .result         (result),
    .failures       (failures),
    .pending        (pending)
  );

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_div(logic [W-1:0] a, logic [W-1:0] b, logic uns, logic word,
                          logic rem);
    start          <= 1'b1;
    dividend       <= a;
    divisor        <= b;
    is_unsigned    <= uns;
    word_mode      <= word;
    want_remainder <= rem;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop start for the given number of cycles with junk on the operand ports
  task automatic idle_gap(int cycles);
    start          <= 1'b0;
    dividend       <= {$urandom, $urandom};
    divisor        <= {$urandom, $urandom};
    is_unsigned    <= 1'($urandom_range(0, 1));
    word_mode      <= 1'($urandom_range(0, 1));
    want_remainder <= 1'($urandom_range(0, 1));
    repeat (cycles) @(negedge clk);
  endtask

  // Operand mix: full random, narrow, small of either sign, word-extended, corners
  function automatic logic [W-1:0] pick_operand(bit for_divisor);
    logic [W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1: ;
      2: v = v >> $urandom_range(1, W - 1);
      3: v = W'($urandom_range(0, 20));
      4: v = -W'($urandom_range(1, 20));
      5: v = {{(W-WB){v[WB-1]}}, v[WB-1:0]};
      6: begin
        case ($urandom_range(0, 7))
          0: v = '0;
          1: v = W'(1);
          2: v = '1;
          3: v = {1'b1, {(W-1){1'b0}}};
          4: v = {1'b0, {(W-1){1'b1}}};
          5: v = 64'h0000_0000_8000_0000;
          6: v = 64'h0000_0000_7fff_ffff;
          default: v = 64'h0000_0000_ffff_ffff;
        endcase
      end
      default: if (for_divisor) v = v >> $urandom_range(WB, W - 1);
    endcase
    return v;
  endfunction

  // Run watchdog
  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

  initial begin
    int idle_pct[3];
    int n;
    idle_pct = '{0, 86, 12};
    rst            = 1'b1;
    start          = 1'b0;
    dividend       = '0;
    divisor        = '0;
    is_unsigned    = 1'b0;
    word_mode      = 1'b0;
    want_remainder = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: sign combinations, divide by zero, most negative, word mode
    send_div(64'd100, 64'd7, 1'b0, 1'b0, 1'b0);
    send_div(64'd100, 64'd7, 1'b0, 1'b0, 1'b1);
    send_div(-64'd100, 64'd7, 1'b0, 1'b0, 1'b0);
    send_div(-64'd100, 64'd7, 1'b0, 1'b0, 1'b1);
    send_div(64'd100, -64'd7, 1'b0, 1'b0, 1'b0);
    send_div(64'd100, -64'd7, 1'b0, 1'b0, 1'b1);
    send_div(-64'd100, -64'd7, 1'b0, 1'b0, 1'b0);
    send_div(-64'd100, -64'd7, 1'b0, 1'b0, 1'b1);
    send_div(-64'd55, 64'd0, 1'b0, 1'b0, 1'b0);
    send_div(-64'd55, 64'd0, 1'b0, 1'b0, 1'b1);
    send_div('1, 64'd0, 1'b1, 1'b0, 1'b0);
    send_div('1, 64'd0, 1'b1, 1'b0, 1'b1);
    send_div('0, '0, 1'b0, 1'b0, 1'b0);
    send_div({1'b1, {(W-1){1'b0}}}, '1, 1'b0, 1'b0, 1'b0);
    send_div({1'b1, {(W-1){1'b0}}}, '1, 1'b0, 1'b0, 1'b1);
    send_div({1'b1, {(W-1){1'b0}}}, 64'd1, 1'b0, 1'b0, 1'b0);
    send_div('1, '1, 1'b1, 1'b0, 1'b0);
    send_div('1, 64'd1, 1'b1, 1'b0, 1'b1);
    send_div(64'hdead_beef_8000_0000, 64'h1234_5678_ffff_ffff, 1'b0, 1'b1, 1'b0);
    send_div(64'hdead_beef_8000_0000, 64'h1234_5678_ffff_ffff, 1'b0, 1'b1, 1'b1);
    send_div(64'hffff_ffff_ffff_fff3, 64'h0000_0000_0000_0005, 1'b1, 1'b1, 1'b0);
    send_div(64'h5555_5555_ffff_fff3, 64'hffff_ffff_0000_0000, 1'b0, 1'b1, 1'b0);
    send_div(64'h5555_5555_ffff_fff3, 64'hffff_ffff_0000_0000, 1'b0, 1'b1, 1'b1);

    // Hold off until the pipeline drains
    idle_gap(1);
    wait (pending == 0);
    @(negedge clk);

    // Random items; each cycle the sender idles with the phase's percentage
    for (int ph = 0; ph < 3; ph++) begin
      n = 530 + $urandom_range(0, 10);
      for (int i = 0; i < n; i++) begin
        while ($urandom_range(0, 99) < idle_pct[ph])
          idle_gap(1);
        send_div(pick_operand(1'b0), pick_operand(1'b1), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end

    // Drain and give the verdict
    idle_gap(1);
    wait (pending == 0);
    repeat (80) @(posedge clk);
    if (failures == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/sudiv_pkg.sv
design/sudiv_prep.sv
design/sudiv_cell.sv
design/sudiv_post.sv
design/signed_unsigned_int_divider.sv
bench/div_checker.sv
bench/tb.sv
